// ===== rtl/core/tdpt_pkg.sv =====
// Package for the trial-division prime test unit: value width, derived widths
// and the sequencer state type. No dependencies.

package tdpt_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  localparam value_t VAL_TWO   = value_t'(2);
  localparam value_t VAL_THREE = value_t'(3);
  localparam value_t VAL_FOUR  = value_t'(4);
  localparam cnt_t   CNT_LAST  = cnt_t'(VALUE_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/core/trial_division_prime_test_unit.sv =====
// Top level of the trial-division prime test unit: sequencer and bit-serial
// restoring divider. Depends on tdpt_pkg.
//
//   channel    | handshake                     | word
//   -----------+-------------------------------+-------------------------------
//   candidate  | cand_valid / cand_stall (out) | candidate, signed VALUE_WIDTH
//   result     | res_valid (out) / res_stall   | is_prime, 1 bit
//
// Flow: negatives, 0..3 and even values go from acceptance straight to the
// finish state, which raises res_valid once the output register is free.
// Odd values from 5 up run one trial division per odd divisor d (one quotient
// bit a cycle in the shared divider, then a check); the test stops at the
// first zero remainder or once d exceeds the quotient. Reset clears the
// sequencer and the result valid flag only; there is no clearing pass. One
// candidate is worked on at a time; the next is taken while a finished
// result still waits in the output register, and a result that finds the
// output register full holds until it is taken.

module trial_division_prime_test_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cand_valid,
  output logic                                   cand_stall,
  input  logic signed [tdpt_pkg::VALUE_WIDTH-1:0] candidate,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic                                   is_prime
);

  localparam int W = tdpt_pkg::VALUE_WIDTH;

  tdpt_pkg::state_t state, state_next;

  tdpt_pkg::value_t value, value_next;     // candidate under test
  tdpt_pkg::value_t divisor, divisor_next; // current odd trial divisor
  tdpt_pkg::value_t rem, rem_next;         // partial remainder
  tdpt_pkg::value_t quo, quo_next;         // dividend bits out, quotient bits in
  tdpt_pkg::cnt_t   cnt, cnt_next;
  logic             verdict, verdict_next;
  logic             res_valid_next, is_prime_next;

  tdpt_pkg::value_t raw;
  logic             accept;
  logic [W:0]       shifted;
  logic [W:0]       diff;
  logic             out_free;

  assign raw      = tdpt_pkg::value_t'($unsigned(candidate));
  assign accept   = cand_valid && !cand_stall;
  assign out_free = !res_valid || !res_stall;

  // One restoring step: bring down the next dividend bit, try the subtract.
  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tdpt_pkg::ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value    <= value_next;
    divisor  <= divisor_next;
    rem      <= rem_next;
    quo      <= quo_next;
    cnt      <= cnt_next;
    verdict  <= verdict_next;
    is_prime <= is_prime_next;
  end

  always_comb begin
    state_next     = state;
    value_next     = value;
    divisor_next   = divisor;
    rem_next       = rem;
    quo_next       = quo;
    cnt_next       = cnt;
    verdict_next   = verdict;
    res_valid_next = res_valid && res_stall;
    is_prime_next  = is_prime;
    cand_stall     = (state != tdpt_pkg::ST_IDLE);

    unique case (state)
      tdpt_pkg::ST_IDLE: begin
        if (accept) begin
          value_next   = raw;
          divisor_next = tdpt_pkg::VAL_THREE;
          rem_next     = '0;
          quo_next     = raw;
          cnt_next     = '0;
          // Settle negatives, small values and even values at once.
          if (raw[W-1] || raw < tdpt_pkg::VAL_TWO) begin
            verdict_next = 1'b0;
            state_next   = tdpt_pkg::ST_FINISH;
          end else if (raw < tdpt_pkg::VAL_FOUR) begin
            verdict_next = 1'b1;
            state_next   = tdpt_pkg::ST_FINISH;
          end else if (!raw[0]) begin
            verdict_next = 1'b0;
            state_next   = tdpt_pkg::ST_FINISH;
          end else begin
            state_next   = tdpt_pkg::ST_DIV;
          end
        end
      end

      tdpt_pkg::ST_DIV: begin
        if (!diff[W]) begin
          rem_next = diff[W-1:0];
          quo_next = {quo[W-2:0], 1'b1};
        end else begin
          rem_next = shifted[W-1:0];
          quo_next = {quo[W-2:0], 1'b0};
        end
        cnt_next = cnt + 1'b1;
        if (cnt == tdpt_pkg::CNT_LAST) begin
          state_next = tdpt_pkg::ST_CHECK;
        end
      end

      tdpt_pkg::ST_CHECK: begin
        // d > v / d means d * d > v: no divisor left, the value is prime.
        if (divisor > quo) begin
          verdict_next = 1'b1;
          state_next   = tdpt_pkg::ST_FINISH;
        end else if (rem == '0) begin
          verdict_next = 1'b0;
          state_next   = tdpt_pkg::ST_FINISH;
        end else begin
          divisor_next = divisor + tdpt_pkg::VAL_TWO;
          rem_next     = '0;
          quo_next     = value;
          cnt_next     = '0;
          state_next   = tdpt_pkg::ST_DIV;
        end
      end

      tdpt_pkg::ST_FINISH: begin
        // Hold the verdict until the output register is free.
        if (out_free) begin
          res_valid_next = 1'b1;
          is_prime_next  = verdict;
          state_next     = tdpt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  // Only odd divisors from three upward are ever tried.
  a_divisor_odd: assert property (@(posedge clk) disable iff (rst)
    (state == tdpt_pkg::ST_DIV) |-> (divisor[0] && divisor >= tdpt_pkg::VAL_THREE))
    else $error("trial divisor is even or below three");

  // The restoring step keeps the partial remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == tdpt_pkg::ST_DIV) |-> (rem < divisor))
    else $error("partial remainder not below divisor");

  // A check only follows a completed division.
  a_check_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == tdpt_pkg::ST_CHECK) |-> ($past(state) == tdpt_pkg::ST_DIV
                                       && $past(cnt) == tdpt_pkg::CNT_LAST))
    else $error("check reached without a full division");

  // An accepted candidate always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != tdpt_pkg::ST_IDLE))
    else $error("accepted candidate was dropped");

  // A result is loaded only from the finish state into a free register.
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == tdpt_pkg::ST_FINISH && out_free) |=> (res_valid && is_prime == $past(verdict)))
    else $error("finished verdict not loaded into the output register");

endmodule
